@@ rtl/usm_pkg.sv @@
// Shared constants, types and coefficients for the UV sphere mesh generator.
package usm_pkg;

	localparam int USM_MAX_SEGMENTS = 256;

	localparam int SEG_W = 9;
	localparam int IDX_W = 17;
	localparam int Q15_W = 16;

	// Fraction bits produced by the divider row: 2 quadrant bits plus a Q30 fraction
	localparam int DIV_STAGES = 32;
	localparam int QUO_W = DIV_STAGES + 1;
	localparam int SINE_LAT = 4;

	localparam logic [30:0] Q30_ONE = 31'd1073741824;
	localparam logic [30:0] POLY_A = 31'd1686629713;
	localparam logic [29:0] POLY_B = 30'd688904866;
	localparam logic [26:0] POLY_C = 27'd76016977;

	typedef enum logic {
		REG_SEGMENTS_X = 1'b0,
		REG_SEGMENTS_Y = 1'b1
	} reg_idx_t;

	typedef enum logic {
		OP_VERTEX = 1'b0,
		OP_STRIP  = 1'b1
	} op_t;

endpackage

@@ rtl/usm_if.sv @@
// Request and result channel interfaces for the UV sphere mesh generator.
interface usm_req_if import usm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             op;
	logic [SEG_W-1:0] column;
	logic [SEG_W-1:0] row;

	modport source (output valid, op, column, row, input ready);
	modport sink (input valid, op, column, row, output ready);
endinterface

interface usm_res_if import usm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [Q15_W-1:0] pos_x;
	logic signed [Q15_W-1:0] pos_y;
	logic signed [Q15_W-1:0] pos_z;
	logic [Q15_W-1:0]        tex_u;
	logic [Q15_W-1:0]        tex_v;
	logic [IDX_W-1:0]        vertex_index;
	logic                    out_of_range;
	logic                    last;

	modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_index,
		out_of_range, last, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_index,
		out_of_range, last, output ready);
endinterface

@@ rtl/uv_sphere_mesh_generator.sv @@
// UV sphere tessellator top level: request decode, divider rows, sine units, output stage.
// Accepts one request per clock unless stalled; a vertex result passes through the input
// register, the row of 32 division cells (one quotient bit each), the 4-stage sine
// polynomial, one product stage and the output register. An in-range strip request yields
// two results and holds the output register until both are taken, so no new request is
// accepted meanwhile. Backpressure on the result channel stalls the whole pipeline.
module uv_sphere_mesh_generator import usm_pkg::*; #(
	parameter int MAX_SEGMENTS = USM_MAX_SEGMENTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [SEG_W-1:0] cfg_data,
	usm_req_if.sink          req,
	usm_res_if.source        res
);

	localparam int NS = DIV_STAGES + SINE_LAT + 1;
	localparam int SQ = DIV_STAGES;

	typedef struct packed {
		logic             op;
		logic             oor;
		logic [IDX_W-1:0] idx_a;
		logic [IDX_W-1:0] idx_b;
		logic [1:0]       quad_u;
		logic [1:0]       quad_v;
		logic [Q15_W-1:0] tex_u;
		logic [Q15_W-1:0] tex_v;
	} item_t;

	function automatic logic [SEG_W-1:0] eff_seg(input logic [SEG_W-1:0] r);
		if (r == '0)
			return SEG_W'(1);
		if (32'(r) > MAX_SEGMENTS)
			return SEG_W'(MAX_SEGMENTS);
		return r;
	endfunction

	function automatic logic [Q15_W-1:0] to_q15(input logic [16:0] m, input logic neg);
		if (m == '0)
			return '0;
		if (neg) begin
			if (m > 17'd32768)
				return 16'h8000;
			return 16'(17'h10000 - m);
		end
		if (m > 17'd32767)
			return 16'h7fff;
		return m[15:0];
	endfunction

	// Configuration
	logic [SEG_W-1:0] seg_x_q, seg_y_q;
	logic [SEG_W-1:0] sx, sy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_x_q <= SEG_W'(64);
			seg_y_q <= SEG_W'(64);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SEGMENTS_X: seg_x_q <= cfg_data;
				REG_SEGMENTS_Y: seg_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sx = eff_seg(seg_x_q);
	assign sy = eff_seg(seg_y_q);

	// Flow control
	logic adv;
	logic out_v_q, beat_q;
	logic two_beat, out_last;
	item_t out_item_q;

	assign two_beat = out_item_q.op == OP_STRIP && !out_item_q.oor;
	assign out_last = !two_beat || beat_q;
	assign adv      = !out_v_q || (res.ready && out_last);
	assign req.ready = adv;

	// Input register
	logic             in_v_q;
	logic             in_op_q;
	logic [SEG_W-1:0] in_col_q, in_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_v_q <= 1'b0;
		else if (adv)
			in_v_q <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_op_q  <= req.op;
			in_col_q <= req.column;
			in_row_q <= req.row;
		end
	end

	// Decode: range check, strip indices, divider seeds
	logic             oor;
	logic [SEG_W:0]   stride;
	logic [SEG_W-1:0] xs;
	logic [18:0]      base, top_idx, bot_idx;
	item_t            item_in;
	logic [SEG_W-1:0] r_u0, r_v0;
	logic [QUO_W-1:0] q_u0, q_v0;

	always_comb begin
		if (in_op_q == OP_VERTEX)
			oor = in_col_q > sx || in_row_q > sy;
		else
			oor = in_row_q >= sy || in_col_q > sx;
		stride  = {1'b0, sx} + (SEG_W+1)'(1);
		xs      = in_row_q[0] ? sx - in_col_q : in_col_q;
		base    = 19'(in_row_q) * 19'(stride);
		top_idx = 19'(base + 19'(xs));
		bot_idx = 19'(top_idx + 19'(stride));

		item_in        = '0;
		item_in.op     = in_op_q;
		item_in.oor    = oor;
		item_in.idx_a  = in_row_q[0] ? bot_idx[IDX_W-1:0] : top_idx[IDX_W-1:0];
		item_in.idx_b  = in_row_q[0] ? top_idx[IDX_W-1:0] : bot_idx[IDX_W-1:0];

		// a full ratio seeds the integer bit and leaves no remainder
		r_u0 = (in_col_q == sx) ? '0 : in_col_q;
		q_u0 = QUO_W'(in_col_q == sx);
		r_v0 = (in_row_q == sy) ? '0 : in_row_q;
		q_v0 = QUO_W'(in_row_q == sy);
	end

	// Divider rows
	logic [SEG_W-1:0] du [DIV_STAGES+1];
	logic [SEG_W-1:0] ru [DIV_STAGES+1];
	logic [QUO_W-1:0] qu [DIV_STAGES+1];
	logic [SEG_W-1:0] dv [DIV_STAGES+1];
	logic [SEG_W-1:0] rv [DIV_STAGES+1];
	logic [QUO_W-1:0] qv [DIV_STAGES+1];

	assign du[0] = sx;
	assign ru[0] = r_u0;
	assign qu[0] = q_u0;
	assign dv[0] = sy;
	assign rv[0] = r_v0;
	assign qv[0] = q_v0;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_cells
		usm_div_cell u_cell_u (
			.clk (clk), .en (adv),
			.d_i (du[k]), .r_i (ru[k]), .q_i (qu[k]),
			.d_o (du[k+1]), .r_o (ru[k+1]), .q_o (qu[k+1])
		);
		usm_div_cell u_cell_v (
			.clk (clk), .en (adv),
			.d_i (dv[k]), .r_i (rv[k]), .q_i (qv[k]),
			.d_o (dv[k+1]), .r_o (rv[k+1]), .q_o (qv[k+1])
		);
	end

	// Sine units
	logic [QUO_W-1:0] yu, yv;
	logic [30:0]      zu, zv, zu_c, zv_c;
	logic [30:0]      su_z, su_c, sv_z, sv_c;

	assign yu   = qu[DIV_STAGES];
	assign yv   = qv[DIV_STAGES];
	assign zu   = {1'b0, yu[29:0]};
	assign zv   = {1'b0, yv[30:1]};
	assign zu_c = Q30_ONE - zu;
	assign zv_c = Q30_ONE - zv;

	usm_qsine u_sin_uz (.clk (clk), .en (adv), .z (zu),   .s (su_z));
	usm_qsine u_sin_uc (.clk (clk), .en (adv), .z (zu_c), .s (su_c));
	usm_qsine u_sin_vz (.clk (clk), .en (adv), .z (zv),   .s (sv_z));
	usm_qsine u_sin_vc (.clk (clk), .en (adv), .z (zv_c), .s (sv_c));

	// Side chain carrying per-request data alongside the arithmetic
	item_t side_q [NS];
	logic  v_q    [NS];
	item_t side_att;

	// attach quadrants and texture coordinates once the quotients are complete
	always_comb begin
		side_att        = side_q[SQ-1];
		side_att.quad_u = yu[31:30];
		side_att.quad_v = yv[32:31];
		side_att.tex_u  = Q15_W'(yu[32:17] + Q15_W'(yu[16]));
		side_att.tex_v  = Q15_W'(yv[32:17] + Q15_W'(yv[16]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++)
				v_q[k] <= 1'b0;
		end else if (adv) begin
			v_q[0] <= in_v_q;
			for (int k = 1; k < NS; k++)
				v_q[k] <= v_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= item_in;
			for (int k = 1; k < NS; k++)
				side_q[k] <= (k == SQ) ? side_att : side_q[k-1];
		end
	end

	// Quadrant selection and products
	item_t       sel_item;
	logic [30:0] cu_m, su_m, cv_m, sv_m;
	logic        cu_n, su_n, cv_n, sv_n;
	logic [61:0] prod_x_q, prod_z_q;
	logic [30:0] cv_mag_q;
	logic        neg_x_q, neg_y_q, neg_z_q;

	assign sel_item = side_q[NS-2];

	always_comb begin
		case (sel_item.quad_u)
			2'd0: begin su_m = su_z; su_n = 1'b0; cu_m = su_c; cu_n = 1'b0; end
			2'd1: begin su_m = su_c; su_n = 1'b0; cu_m = su_z; cu_n = 1'b1; end
			2'd2: begin su_m = su_z; su_n = 1'b1; cu_m = su_c; cu_n = 1'b1; end
			default: begin su_m = su_c; su_n = 1'b1; cu_m = su_z; cu_n = 1'b0; end
		endcase
		case (sel_item.quad_v)
			2'd0: begin sv_m = sv_z; sv_n = 1'b0; cv_m = sv_c; cv_n = 1'b0; end
			2'd1: begin sv_m = sv_c; sv_n = 1'b0; cv_m = sv_z; cv_n = 1'b1; end
			2'd2: begin sv_m = sv_z; sv_n = 1'b1; cv_m = sv_c; cv_n = 1'b1; end
			default: begin sv_m = sv_c; sv_n = 1'b1; cv_m = sv_z; cv_n = 1'b0; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_q <= cu_m * sv_m;
			prod_z_q <= su_m * sv_m;
			cv_mag_q <= cv_m;
			neg_x_q  <= cu_n ^ sv_n;
			neg_z_q  <= su_n ^ sv_n;
			neg_y_q  <= cv_n;
		end
	end

	// Rounding, saturation and output register
	item_t       fin_item;
	item_t       fin_clr;
	logic [62:0] rx, rz;
	logic [31:0] ry;
	logic        zero_pos;
	logic [Q15_W-1:0] px_q, py_q, pz_q;

	assign fin_item = side_q[NS-1];
	assign rx       = {1'b0, prod_x_q} + (63'd1 << 44);
	assign rz       = {1'b0, prod_z_q} + (63'd1 << 44);
	assign ry       = {1'b0, cv_mag_q} + (32'd1 << 14);
	assign zero_pos = fin_item.op == OP_STRIP || fin_item.oor;

	always_comb begin
		fin_clr = fin_item;
		if (zero_pos) begin
			fin_clr.tex_u = '0;
			fin_clr.tex_v = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			beat_q  <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_q[NS-1];
			beat_q  <= 1'b0;
		end else if (res.ready) begin
			// first beat of a strip pair taken: advance to the second
			beat_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item_q <= fin_clr;
			px_q <= zero_pos ? '0 : to_q15(rx[61:45], neg_x_q);
			py_q <= zero_pos ? '0 : to_q15(ry[31:15], neg_y_q);
			pz_q <= zero_pos ? '0 : to_q15(rz[61:45], neg_z_q);
		end
	end

	assign res.valid        = out_v_q;
	assign res.pos_x        = px_q;
	assign res.pos_y        = py_q;
	assign res.pos_z        = pz_q;
	assign res.tex_u        = out_item_q.tex_u;
	assign res.tex_v        = out_item_q.tex_v;
	assign res.vertex_index = two_beat ? (beat_q ? out_item_q.idx_b : out_item_q.idx_a) : '0;
	assign res.out_of_range = out_item_q.oor;
	assign res.last         = out_last;

	// Assertions
	a_pair_second: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && !res.last |=> res.valid && res.last)
		else $error("strip pair lost its second result");

	a_hold_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_last |-> !req.ready)
		else $error("request taken while a strip pair is pending");

	a_oor_single: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.out_of_range |-> res.last && res.vertex_index == '0)
		else $error("out-of-range result not a single empty transaction");

endmodule

@@ rtl/usm_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per stage.
module usm_div_cell import usm_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [SEG_W-1:0] d_i,
	input  logic [SEG_W-1:0] r_i,
	input  logic [QUO_W-1:0] q_i,
	output logic [SEG_W-1:0] d_o,
	output logic [SEG_W-1:0] r_o,
	output logic [QUO_W-1:0] q_o
);

	logic [SEG_W:0] t;
	logic [SEG_W:0] diff;
	logic           ge;

	assign t    = {r_i, 1'b0};
	assign ge   = t >= {1'b0, d_i};
	assign diff = t - {1'b0, d_i};

	always_ff @(posedge clk) begin
		if (en) begin
			d_o <= d_i;
			r_o <= ge ? diff[SEG_W-1:0] : t[SEG_W-1:0];
			q_o <= {q_i[QUO_W-2:0], ge};
		end
	end

endmodule

@@ rtl/usm_qsine.sv @@
// Pipelined quarter-wave sine polynomial, Q30 in and out.
module usm_qsine import usm_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] z,
	output logic [30:0] s
);

	logic [61:0] zz;
	logic [30:0] z_s1, z_s2, z_s3;
	logic [30:0] z2_s1, z2_s2;
	logic [57:0] cz;
	logic [27:0] m1_s2;
	logic [29:0] t;
	logic [60:0] tz;
	logic [30:0] m2_s3;
	logic [30:0] p;
	logic [61:0] pz;

	assign zz = z * z;
	assign cz = POLY_C * z2_s1;
	assign t  = POLY_B - 30'(m1_s2);
	assign tz = t * z2_s2;
	assign p  = POLY_A - m2_s3;
	assign pz = p * z_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1  <= z;
			z2_s1 <= zz[60:30];
			z_s2  <= z_s1;
			z2_s2 <= z2_s1;
			m1_s2 <= cz[57:30];
			z_s3  <= z_s2;
			m2_s3 <= tz[60:30];
			s     <= pz[60:30];
		end
	end

endmodule

@@ tb/tb_uv_sphere_mesh_generator.sv @@
// Self-checking testbench for the UV sphere mesh generator: vertex and strip requests.
`timescale 1ns / 1ps
module tb_uv_sphere_mesh_generator;
	import usm_pkg::*;

	typedef struct {
		logic op;
		logic [SEG_W-1:0] column;
		logic [SEG_W-1:0] row;
	} request_t;

	typedef struct {
		logic [15:0] pos_x, pos_y, pos_z, tex_u, tex_v;
		logic [IDX_W-1:0] vertex_index;
		logic out_of_range, last;
	} mesh_result_t;

	localparam int IDLE_LIMIT = 20000;
	localparam longint Q30 = 64'd1073741824;
	localparam longint PA = 64'd1686629713;
	localparam longint PB = 64'd688904866;
	localparam longint PC = Q30 - PA + PB;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [SEG_W-1:0] cfg_data = '0;

	usm_req_if req ();
	usm_res_if res ();

	uv_sphere_mesh_generator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .res(res)
	);

	request_t pending_reqs[$];
	mesh_result_t expected_results[$];
	int unsigned seg_x_reg = 64, seg_y_reg = 64;
	int errors = 0;
	int idle_cycles = 0;
	int results_seen = 0;
	int vertex_count = 0, strip_count = 0, range_count = 0;
	int drv_wait = 0, mon_wait = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint qsine(longint z);
		longint z2, t, p;
		z2 = (z * z) >> 30;
		t = PB - ((PC * z2) >> 30);
		p = PA - ((t * z2) >> 30);
		return (p * z) >> 30;
	endfunction

	// sine and cosine of k*n/d quarter turns, as magnitude and sign
	task automatic quarter_turns(input longint n, input longint d, input longint k,
		output longint sm, output bit sn, output longint cm, output bit cn);
		longint q, z, sz, sc;
		int quad;
		q = k * n;
		quad = int'((q / d) % 4);
		z = ((q % d) << 30) / d;
		sz = qsine(z);
		sc = qsine(Q30 - z);
		case (quad)
			0: begin sm = sz; sn = 0; cm = sc; cn = 0; end
			1: begin sm = sc; sn = 0; cm = sz; cn = 1; end
			2: begin sm = sz; sn = 1; cm = sc; cn = 1; end
			default: begin sm = sc; sn = 1; cm = sz; cn = 0; end
		endcase
	endtask

	function automatic logic [15:0] saturate_q15(longint m, bit neg);
		if (m == 0) return 16'd0;
		if (neg) begin
			if (m > 32768) m = 32768;
			return 16'((65536 - m) & 16'hFFFF);
		end
		if (m > 32767) m = 32767;
		return 16'(m);
	endfunction

	function automatic logic [15:0] product_q15(longint a, longint b, bit neg);
		logic [63:0] p;
		p = 64'(a) * 64'(b) + (64'd1 << 44);
		return saturate_q15(longint'(p >> 45), neg);
	endfunction

	function automatic int unsigned clamp_segments(int unsigned r);
		if (r == 0) return 1;
		if (r > USM_MAX_SEGMENTS) return USM_MAX_SEGMENTS;
		return r;
	endfunction

	task automatic add_expected(input mesh_result_t r);
		expected_results = {expected_results, r};
	endtask

	task automatic predict_mesh(input request_t rq);
		mesh_result_t a, b;
		int unsigned sx, sy, x;
		longint sum, sun, cum, cun, svm, cvm;
		bit sus, cus, svs, cvs;
		longint stride, top, bottom;
		sx = clamp_segments(seg_x_reg);
		sy = clamp_segments(seg_y_reg);
		a = '{default: '0};
		b = '{default: '0};
		if (rq.op == OP_VERTEX) begin
			vertex_count++;
			a.last = 1;
			if (rq.column > sx || rq.row > sy) begin
				a.out_of_range = 1;
				range_count++;
			end else begin
				quarter_turns(rq.column, sx, 4, sum, sus, cum, cus);
				quarter_turns(rq.row, sy, 2, svm, svs, cvm, cvs);
				a.pos_x = product_q15(cum, svm, cus != svs);
				a.pos_y = saturate_q15((cvm + (64'd1 << 14)) >> 15, cvs);
				a.pos_z = product_q15(sum, svm, sus != svs);
				a.tex_u = 16'(((longint'(rq.column) << 15) + sx / 2) / sx);
				a.tex_v = 16'(((longint'(rq.row) << 15) + sy / 2) / sy);
			end
			add_expected(a);
		end else begin
			strip_count++;
			if (rq.row >= sy || rq.column > sx) begin
				a.out_of_range = 1;
				a.last = 1;
				range_count++;
				add_expected(a);
			end else begin
				stride = sx + 1;
				x = rq.row[0] ? sx - rq.column : rq.column;
				top = rq.row * stride + x;
				bottom = (rq.row + 1) * stride + x;
				a.vertex_index = IDX_W'(rq.row[0] ? bottom : top);
				b.vertex_index = IDX_W'(rq.row[0] ? top : bottom);
				b.last = 1;
				add_expected(a);
				add_expected(b);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver: one transaction per item, random gap between items
	initial begin
		req.valid = 1'b0;
		req.op = 1'b0;
		req.column = '0;
		req.row = '0;
		res.ready = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (drv_wait > 0) begin
				drv_wait--;
				req.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				req.valid <= 1'b1;
				req.op <= pending_reqs[0].op;
				req.column <= pending_reqs[0].column;
				req.row <= pending_reqs[0].row;
			end else begin
				req.valid <= 1'b0;
			end
			if (mon_wait > 0) begin
				mon_wait--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// monitor: record accepted requests, compare each result with the oldest expectation
	always @(posedge clk) begin
		mesh_result_t e;
		if (arst_n) begin
			if ((req.valid && req.ready) || (res.valid && res.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (req.valid && req.ready) begin
				predict_mesh('{req.op, req.column, req.row});
				void'(pending_reqs.pop_front());
				drv_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			end
			if (res.valid && res.ready) begin
				results_seen++;
				mon_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					e = expected_results.pop_front();
					if (res.pos_x !== e.pos_x) report_mismatch("pos_x", res.pos_x, e.pos_x);
					if (res.pos_y !== e.pos_y) report_mismatch("pos_y", res.pos_y, e.pos_y);
					if (res.pos_z !== e.pos_z) report_mismatch("pos_z", res.pos_z, e.pos_z);
					if (res.tex_u !== e.tex_u) report_mismatch("tex_u", res.tex_u, e.tex_u);
					if (res.tex_v !== e.tex_v) report_mismatch("tex_v", res.tex_v, e.tex_v);
					if (res.vertex_index !== e.vertex_index)
						report_mismatch("vertex_index", res.vertex_index, e.vertex_index);
					if (res.out_of_range !== e.out_of_range)
						report_mismatch("out_of_range", res.out_of_range, e.out_of_range);
					if (res.last !== e.last) report_mismatch("last", res.last, e.last);
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic push_req(input logic op, input int unsigned c, input int unsigned r);
		request_t rq;
		rq = '{op, SEG_W'(c), SEG_W'(r)};
		pending_reqs = {pending_reqs, rq};
	endtask

	task automatic drain;
		while (pending_reqs.size() > 0 || expected_results.size() > 0 || req.valid)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_segments(input reg_idx_t idx, input int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= SEG_W'(value);
		if (idx == REG_SEGMENTS_X) seg_x_reg = value;
		else seg_y_reg = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly in-grid requests with some beyond the grid edge
	task automatic random_phase(input int n);
		int unsigned sx, sy, c, r;
		sx = clamp_segments(seg_x_reg);
		sy = clamp_segments(seg_y_reg);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				c = $urandom_range(0, 511);
				r = $urandom_range(0, 511);
			end else begin
				c = $urandom_range(0, sx);
				r = $urandom_range(0, sy);
			end
			push_req($urandom_range(0, 1), c, r);
		end
		drain();
	endtask

	int unsigned sx_list[8] = '{0, 1, 2, 3, 256, 300, 511, 7};
	int unsigned sy_list[8] = '{1, 0, 255, 256, 3, 511, 17, 100};

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// directed: reset geometry, grid corners, poles, seam, out of grid, both parities
		push_req(OP_VERTEX, 0, 0);
		push_req(OP_VERTEX, 64, 64);
		push_req(OP_VERTEX, 16, 32);
		push_req(OP_VERTEX, 32, 16);
		push_req(OP_VERTEX, 48, 48);
		push_req(OP_VERTEX, 65, 0);
		push_req(OP_VERTEX, 0, 65);
		push_req(OP_VERTEX, 511, 511);
		push_req(OP_STRIP, 0, 0);
		push_req(OP_STRIP, 64, 0);
		push_req(OP_STRIP, 0, 1);
		push_req(OP_STRIP, 64, 63);
		push_req(OP_STRIP, 0, 64);
		push_req(OP_STRIP, 65, 2);
		push_req(OP_STRIP, 511, 511);
		push_req(OP_VERTEX, 256, 256);
		drain();
		random_phase(300);
		for (int k = 0; k < 8; k++) begin
			write_segments(REG_SEGMENTS_X, sx_list[k]);
			write_segments(REG_SEGMENTS_Y, sy_list[k]);
			push_req(OP_VERTEX, 256, 256);
			push_req(OP_STRIP, 256, 255);
			push_req(OP_STRIP, 0, 0);
			random_phase(200);
		end
		$display("covered %0d vertex and %0d strip requests over 9 grid settings",
			vertex_count, strip_count);
		$display("%0d results checked, %0d outside the grid", results_seen, range_count);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
